// ----- hw/rtl/t8p4q_pkg.sv -----
// shared types and constants for the nhwc to 8p4c remap and int8 quantizer
// no dependencies
`default_nettype none

package t8p4q_pkg;

  typedef struct packed {
    logic [1:0]  batch_index;
    logic [5:0]  row;
    logic [5:0]  column;
    logic [9:0]  channel;
    logic [31:0] value_bits;
  } in_beat_t;

  typedef struct packed {
    logic [23:0]        dest_offset;
    logic signed [7:0]  quantized;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic signed [7:0] quantized;
    logic              saturated;
  } quant_res_t;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT      = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH_GROUPS   = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_GROUPS = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_SHIFT    = 8'd3;

  localparam logic [6:0] ROW_COUNT_RST      = 7'd8;
  localparam logic [3:0] WIDTH_GROUPS_RST   = 4'd1;
  localparam logic [8:0] CHANNEL_GROUPS_RST = 9'd64;
  localparam logic [4:0] SCALE_SHIFT_RST    = 5'd7;

endpackage

`default_nettype wire

// ----- hw/rtl/t8p4q_quant.sv -----
// binary32 to int8 floor quantizer with power of two scale and saturation
// uses t8p4q_pkg
`default_nettype none

module t8p4q_quant import t8p4q_pkg::*; (
  input  wire logic [31:0] value_bits_i,
  input  wire logic [4:0]  shift_i,
  output quant_res_t       res_o
);

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [23:0] sig;
  logic [8:0]  eff_exp;
  logic [7:0]  sa;
  logic [23:0] int_part;
  logic [23:0] frac_mask;
  logic        frac_nz;
  logic [7:0]  mag;

  assign sign = value_bits_i[31];
  assign expo = value_bits_i[30:23];
  assign mant = value_bits_i[22:0];
  assign sig  = {(expo != 8'd0), mant};

  // biased exponent after scaling, subnormals use exponent one
  assign eff_exp = ((expo == 8'd0) ? 9'd1 : {1'b0, expo}) + {4'd0, shift_i};
  // right shift bringing the binary point to bit zero, used only below 134
  assign sa = 8'(9'd150 - eff_exp);

  always_comb begin
    if (sa >= 8'd24) begin
      int_part  = '0;
      frac_mask = '1;
    end else begin
      int_part  = sig >> sa[4:0];
      frac_mask = ~(24'hFF_FFFF << sa[4:0]);
    end
  end

  assign frac_nz = (sig & frac_mask) != 24'd0;
  assign mag     = int_part[7:0];

  always_comb begin
    if (expo == 8'hFF && mant != 23'd0) begin
      res_o.quantized = 8'sd0;
      res_o.saturated = 1'b1;
    end else if (expo == 8'hFF || eff_exp >= 9'd134) begin
      // magnitude at least 128, minus exactly 128 still fits
      if (!sign) begin
        res_o.quantized = 8'sd127;
        res_o.saturated = 1'b1;
      end else begin
        res_o.quantized = -8'sd128;
        res_o.saturated = !(expo != 8'hFF && eff_exp == 9'd134 && mant == 23'd0);
      end
    end else if (!sign) begin
      res_o.quantized = signed'(mag);
      res_o.saturated = 1'b0;
    end else begin
      res_o.quantized = signed'(8'(8'd0 - mag - {7'd0, frac_nz}));
      res_o.saturated = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tensor_8p4c_quantize_remap_top.sv -----
// pipeline: an accepted input beat is registered in stage one, stage two and stage three before its output beat
// throughput: one beat per cycle, every stage advances each cycle unless the output stalls
// reset: config registers return to rows 8, width groups 1, channel groups 64,
// shift 7; the pipeline is emptied, no beat is in flight after reset
// uses t8p4q_pkg and t8p4q_quant
`default_nettype none

module tensor_8p4c_quantize_remap_top import t8p4q_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_beat_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_beat_t                out_data_o
);

  // configuration registers
  logic [6:0] row_count_q;
  logic [3:0] width_groups_q;
  logic [8:0] channel_groups_q;
  logic [4:0] scale_shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q      <= ROW_COUNT_RST;
      width_groups_q   <= WIDTH_GROUPS_RST;
      channel_groups_q <= CHANNEL_GROUPS_RST;
      scale_shift_q    <= SCALE_SHIFT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:      row_count_q      <= cfg_data_i[6:0];
        CFG_WIDTH_GROUPS:   width_groups_q   <= cfg_data_i[3:0];
        CFG_CHANNEL_GROUPS: channel_groups_q <= cfg_data_i[8:0];
        CFG_SCALE_SHIFT:    scale_shift_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: each stage moves when empty or when the next one moves
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic en1, en2, en3;

  assign en3 = !s3_valid_q || !out_stall_i;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
    end
  end

  // stage one: input register
  in_beat_t s1_q;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= in_data_i;
  end

  // stage two: line size, row index within the tensor, low offset part, quantize
  logic [12:0] line_d, line_q;
  logic [9:0]  rows_d, rows_q;
  logic [17:0] lo_d, lo_q;
  quant_res_t  qres_d, qres_q;

  // line = width_groups * channel_groups, in units of 32 elements
  assign line_d = {9'd0, width_groups_q} * {4'd0, channel_groups_q};
  // batch * row_count + row, the row index counted over all batches
  assign rows_d = {8'd0, s1_q.batch_index} * {3'd0, row_count_q} + {4'd0, s1_q.row};
  // channel group * 32W + column group * 32 + pixel * 4 + channel lane
  assign lo_d = {1'b0, ({4'd0, s1_q.channel[9:2]} * {8'd0, width_groups_q}), 5'd0}
              + {10'd0, s1_q.column[5:3], 5'd0}
              + {13'd0, s1_q.column[2:0], 2'd0}
              + {16'd0, s1_q.channel[1:0]};

  t8p4q_quant u_quant (
    .value_bits_i (s1_q.value_bits),
    .shift_i      (scale_shift_q),
    .res_o        (qres_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      line_q <= line_d;
      rows_q <= rows_d;
      lo_q   <= lo_d;
      qres_q <= qres_d;
    end
  end

  // stage three: output register, offset wraps to 24 bits
  logic [22:0] row_base;
  out_beat_t   s3_q;

  assign row_base = {13'd0, rows_q} * {10'd0, line_q};

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      s3_q.dest_offset <= {row_base[18:0], 5'd0} + {6'd0, lo_q};
      s3_q.quantized   <= qres_q.quantized;
      s3_q.saturated   <= qres_q.saturated;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_q;

endmodule

`default_nettype wire
